>>> hw/rtl/lfu_page_map_cache_macros.svh
// assertion macros for the lfu page map cache
`ifndef LFU_PAGE_MAP_CACHE_MACROS_SVH
`define LFU_PAGE_MAP_CACHE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LFU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lfu_pmc_pkg.sv
// shared types and constants of the lfu page map cache
package lfu_pmc_pkg;

   // fixed port widths
   localparam int PORT_PAGE_W = 16;
   localparam int CAP_W       = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_WRITE,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;          // capture request, clear scan results
      logic scan;          // lookup and minimum pass
      logic shift_start;   // latch victim, start closing the gap
      logic shift;         // move entries down one place
      logic occ_dec;       // drop one entry from the count
      logic write;         // hit update or append
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic pass_done;     // current memory pass has drained
      logic need_evict;    // miss with the list at capacity
   } dp_stat_type;

endpackage

>>> hw/rtl/lfu_pmc_ctrl.sv
// control state machine of the lfu page map cache
module lfu_pmc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     rsp_busy,
   input  logic                     rsp_ready,
   output logic                     rsp_load,
   input  lfu_pmc_pkg::dp_stat_type stat,
   output lfu_pmc_pkg::dp_cmd_type  cmd
);

   lfu_pmc_pkg::state_type state_ff;
   lfu_pmc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfu_pmc_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfu_pmc_pkg::ST_SCAN;
         end
         lfu_pmc_pkg::ST_SCAN: begin
            if (stat.pass_done) begin
               if (stat.need_evict) state_in = lfu_pmc_pkg::ST_SHIFT;
               else                 state_in = lfu_pmc_pkg::ST_WRITE;
            end
         end
         lfu_pmc_pkg::ST_SHIFT: begin
            if (stat.pass_done) state_in = lfu_pmc_pkg::ST_WRITE;
         end
         lfu_pmc_pkg::ST_WRITE: begin
            state_in = lfu_pmc_pkg::ST_RESP;
         end
         lfu_pmc_pkg::ST_RESP: begin
            if (!rsp_busy || rsp_ready) state_in = lfu_pmc_pkg::ST_IDLE;
         end
         default: state_in = lfu_pmc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         lfu_pmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lfu_pmc_pkg::ST_SCAN: begin
            cmd.scan        = 1'b1;
            cmd.shift_start = stat.pass_done && stat.need_evict;
         end
         lfu_pmc_pkg::ST_SHIFT: begin
            cmd.shift   = 1'b1;
            cmd.occ_dec = stat.pass_done;
         end
         lfu_pmc_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
         end
         lfu_pmc_pkg::ST_RESP: begin
            rsp_load = !rsp_busy || rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/lfu_pmc_dpath.sv
// entry memory, lookup, minimum search and shift datapath of the lfu page map cache
module lfu_pmc_dpath #(
   parameter int ENTRIES    = 16,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lfu_pmc_pkg::dp_cmd_type               cmd,
   output lfu_pmc_pkg::dp_stat_type              stat,
   input  logic [lfu_pmc_pkg::CAP_W-1:0]         capacity,
   input  logic [lfu_pmc_pkg::PORT_PAGE_W-1:0]   req_page,
   output logic                                  res_was_present,
   output logic                                  res_evicted_valid,
   output logic [lfu_pmc_pkg::PORT_PAGE_W-1:0]   res_evicted_page
);

   localparam int OCCW    = $clog2(ENTRIES + 1);
   localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENTRY_W = PAGE_BITS + COUNT_BITS;
   localparam int PW      = lfu_pmc_pkg::PORT_PAGE_W;
   localparam int WIDE_W  = (PAGE_BITS > PW) ? PAGE_BITS : PW;
   localparam int CMP_W   = (OCCW > lfu_pmc_pkg::CAP_W) ? OCCW : lfu_pmc_pkg::CAP_W;

   // entry memory: page in the upper bits, hit count in the lower bits
   logic [ENTRY_W-1:0]    entry_mem [ENTRIES];

   logic [OCCW-1:0]       occ_ff;
   logic [OCCW-1:0]       addr_ff;
   logic                  rd_vld_ff;
   logic [IDXW-1:0]       rd_idx_ff;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  found_ff;
   logic [IDXW-1:0]       match_idx_ff;
   logic [COUNT_BITS-1:0] match_hits_ff;
   logic                  have_min_ff;
   logic [IDXW-1:0]       min_idx_ff;
   logic [COUNT_BITS-1:0] min_hits_ff;
   logic [PAGE_BITS-1:0]  min_page_ff;
   logic                  ev_valid_ff;
   logic [PAGE_BITS-1:0]  ev_page_ff;

   logic                  rd_issue;
   logic [PAGE_BITS-1:0]  rd_page;
   logic [COUNT_BITS-1:0] rd_hits;
   logic [COUNT_BITS-1:0] hits_inc;
   logic                  wr_en;
   logic [IDXW-1:0]       wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [WIDE_W-1:0]     req_wide;
   logic [WIDE_W-1:0]     ev_wide;
   logic [CMP_W-1:0]      cap_w;
   logic [CMP_W-1:0]      occ_w;
   logic [CMP_W-1:0]      ent_w;
   logic [CMP_W-1:0]      eff_cap;

   assign rd_issue = (cmd.scan || cmd.shift) && (addr_ff < occ_ff);
   assign rd_page  = rd_data_ff[ENTRY_W-1 -: PAGE_BITS];
   assign rd_hits  = rd_data_ff[COUNT_BITS-1:0];
   assign hits_inc = (&match_hits_ff) ? match_hits_ff : match_hits_ff + COUNT_BITS'(1);
   assign req_wide = WIDE_W'(req_page);
   assign ev_wide  = WIDE_W'(ev_page_ff);

   // effective capacity, clamped to one .. entries
   assign cap_w = CMP_W'(capacity);
   assign occ_w = CMP_W'(occ_ff);
   assign ent_w = CMP_W'(ENTRIES);
   always_comb begin
      priority if (cap_w == '0) eff_cap = CMP_W'(1);
      else if (cap_w > ent_w)   eff_cap = ent_w;
      else                      eff_cap = cap_w;
   end

   // status
   assign stat.pass_done  = (addr_ff == occ_ff) && !rd_vld_ff;
   assign stat.need_evict = !found_ff && (occ_w != '0) && (occ_w >= eff_cap);

   // memory write selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data_ff;
      priority if (cmd.shift && rd_vld_ff) begin
         wr_en = 1'b1;
      end else if (cmd.write) begin
         wr_en = 1'b1;
         if (found_ff) begin
            wr_addr = match_idx_ff;
            wr_data = {page_ff, hits_inc};
         end else begin
            wr_addr = occ_ff[IDXW-1:0];
            wr_data = {page_ff, COUNT_BITS'(1)};
         end
      end else begin
         wr_en = 1'b0;
      end
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      if (rd_issue) rd_data_ff <= entry_mem[addr_ff[IDXW-1:0]];
   end

   // pass sequencing: address counter and read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.shift_start) begin
         addr_ff   <= OCCW'(min_idx_ff) + OCCW'(1);
         rd_vld_ff <= 1'b0;
      end else if (rd_issue) begin
         addr_ff   <= addr_ff + OCCW'(1);
         rd_vld_ff <= 1'b1;
      end else begin
         rd_vld_ff <= 1'b0;
      end
   end

   // read index: same slot while scanning, one below while shifting
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         if (cmd.shift) rd_idx_ff <= IDXW'(addr_ff - OCCW'(1));
         else           rd_idx_ff <= addr_ff[IDXW-1:0];
      end
   end

   // lookup and first-minimum tracking during the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         have_min_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff    <= 1'b0;
         have_min_ff <= 1'b0;
      end else if (cmd.scan && rd_vld_ff) begin
         if (!found_ff && (rd_page == page_ff)) begin
            found_ff <= 1'b1;
         end
         if (!have_min_ff || (rd_hits < min_hits_ff)) begin
            have_min_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && rd_vld_ff) begin
         if (!found_ff && (rd_page == page_ff)) begin
            match_idx_ff  <= rd_idx_ff;
            match_hits_ff <= rd_hits;
         end
         if (!have_min_ff || (rd_hits < min_hits_ff)) begin
            min_idx_ff  <= rd_idx_ff;
            min_hits_ff <= rd_hits;
            min_page_ff <= rd_page;
         end
      end
   end

   // request page and eviction record
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_wide[PAGE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
         ev_page_ff  <= '0;
      end else if (cmd.load) begin
         ev_valid_ff <= 1'b0;
         ev_page_ff  <= '0;
      end else if (cmd.shift_start) begin
         ev_valid_ff <= 1'b1;
         ev_page_ff  <= min_page_ff;
      end
   end

   // occupancy count
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.occ_dec) begin
         occ_ff <= occ_ff - OCCW'(1);
      end else if (cmd.write && !found_ff) begin
         occ_ff <= occ_ff + OCCW'(1);
      end
   end

   assign res_was_present   = found_ff;
   assign res_evicted_valid = ev_valid_ff;
   assign res_evicted_page  = ev_wide[PW-1:0];

endmodule

>>> hw/rtl/lfu_page_map_cache.sv
// top level of the lfu page map cache: config register, result register, assertions
// Each accepted page access returns one result telling whether the page was
// already listed and, on a miss with the list at capacity, which page was
// evicted (the first entry holding the smallest hit count). An access takes
// the request, runs a lookup and minimum pass that reads the entry memory
// once per listed entry, on an eviction runs a shift pass over the entries
// above the victim, then writes the hit count or the new entry and loads the
// result register.
// Requests are taken one at a time; the result register lets a new access be
// accepted while the previous result still waits on rsp_ready. The capacity
// register resets to sixteen; zero acts as one and values above the entry
// count act as the entry count.
`include "lfu_page_map_cache_macros.svh"

module lfu_page_map_cache #(
   parameter int ENTRIES    = 16,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lfu_pmc_pkg::PORT_PAGE_W-1:0] req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_was_present,
   output logic                                rsp_evicted_valid,
   output logic [lfu_pmc_pkg::PORT_PAGE_W-1:0] rsp_evicted_page,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lfu_pmc_pkg::CAP_W-1:0]       csr_capacity
);

   lfu_pmc_pkg::dp_cmd_type            cmd;
   lfu_pmc_pkg::dp_stat_type           stat;
   logic [lfu_pmc_pkg::CAP_W-1:0]      capacity_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_was_present_ff;
   logic                               rsp_evicted_valid_ff;
   logic [lfu_pmc_pkg::PORT_PAGE_W-1:0] rsp_evicted_page_ff;
   logic                               rsp_load;
   logic                               res_was_present;
   logic                               res_evicted_valid;
   logic [lfu_pmc_pkg::PORT_PAGE_W-1:0] res_evicted_page;

   // capacity register, always ready for a transfer
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfu_pmc_pkg::CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_capacity;
      end
   end

   lfu_pmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_busy  (rsp_valid_ff),
      .rsp_ready (rsp_ready),
      .rsp_load  (rsp_load),
      .stat      (stat),
      .cmd       (cmd)
   );

   lfu_pmc_dpath #(
      .ENTRIES    (ENTRIES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .capacity          (capacity_ff),
      .req_page          (req_page_number),
      .res_was_present   (res_was_present),
      .res_evicted_valid (res_evicted_valid),
      .res_evicted_page  (res_evicted_page)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_was_present_ff   <= res_was_present;
         rsp_evicted_valid_ff <= res_evicted_valid;
         rsp_evicted_page_ff  <= res_evicted_page;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_present   = rsp_was_present_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;

   // a hit never evicts
   `LFU_ASSERT_NOW(a_hit_no_evict, clock, reset, rsp_valid, !(rsp_was_present && rsp_evicted_valid), "hit reported with an eviction")

   // no eviction reports page zero
   `LFU_ASSERT_NOW(a_evict_page_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0, "evicted page set without an eviction")

   // one access at a time: busy right after a request transfer
   `LFU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // a new result never lands on a pending one
   `LFU_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready, "result register overwritten")

endmodule
